@@ rtl/core/swrb_pkg.sv @@
// ----------------------------------------------------------------------------
// swrb_pkg
// Shared types, codes and widths for the stack with recycle bin block.
// ----------------------------------------------------------------------------
package swrb_pkg;

   localparam int POOL_DEPTH_DEF = 64;

   localparam int REQ_W   = 3;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 7;

   // request kinds
   localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_MOVE    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RESTORE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_MAIN_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_BIN_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_POOL_FULL  = 2'd3;

   typedef logic [3:0] op_type;

   // datapath operations
   localparam op_type OP_NONE      = 4'd0;
   localparam op_type OP_RD_LINK   = 4'd1;
   localparam op_type OP_PUSH_FREE = 4'd2;
   localparam op_type OP_PUSH_NEW  = 4'd3;
   localparam op_type OP_MOVE      = 4'd4;
   localparam op_type OP_DESTROY   = 4'd5;
   localparam op_type OP_RESTORE   = 4'd6;
   localparam op_type OP_RD_TOP    = 4'd7;
   localparam op_type OP_LOAD_OUT  = 4'd8;

   typedef logic [1:0] sel_type;

   // head select for link reads
   localparam sel_type SEL_MAIN = 2'd0;
   localparam sel_type SEL_BIN  = 2'd1;
   localparam sel_type SEL_FREE = 2'd2;

   typedef struct packed {
      op_type            op;
      sel_type           rd_sel;
      logic              cap_value;
      logic              st_ld;
      logic [STAT_W-1:0] st_code;
   } cmd_type;

   typedef struct packed {
      logic main_null;
      logic bin_null;
      logic free_null;
      logic pool_full;
      logic link_null;
      logic main_cnt_zero;
   } stat_type;

endpackage

@@ rtl/core/swrb_if.sv @@
// ----------------------------------------------------------------------------
// swrb_if
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface swrb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [swrb_pkg::REQ_W-1:0]    req_type;
   logic signed [swrb_pkg::VALUE_W-1:0]  push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface swrb_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [swrb_pkg::VALUE_W-1:0]  top_value;
   logic                                 top_valid;
   logic        [swrb_pkg::STAT_W-1:0]   status;
   logic        [swrb_pkg::CNT_W-1:0]    stack_count;
   logic        [swrb_pkg::CNT_W-1:0]    bin_count;

   modport source (output valid, output top_value, output top_valid, output status,
                   output stack_count, output bin_count, input ready);
   modport sink   (input valid, input top_value, input top_valid, input status,
                   input stack_count, input bin_count, output ready);
endinterface

@@ rtl/core/swrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// swrb_ctrl
// Request sequencer: decodes one request and steps the datapath through it.
// ----------------------------------------------------------------------------
module swrb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [swrb_pkg::REQ_W-1:0]    req_type,
   output logic                          req_ready,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   input  swrb_pkg::stat_type            stat,
   output swrb_pkg::cmd_type             cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_LINK   = 3'd2;
   localparam logic [2:0] S_CLRRD  = 3'd3;
   localparam logic [2:0] S_TOP    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0]                       state_ff, state_in;
   logic [swrb_pkg::REQ_W-1:0]       kind_ff, kind_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.op       = swrb_pkg::OP_NONE;
      cmd.rd_sel   = swrb_pkg::SEL_MAIN;
      cmd.st_code  = swrb_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in       = req_type;
               cmd.cap_value = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.st_ld = 1'b1;
            state_in  = S_TOP;
            case (kind_ff)
               swrb_pkg::REQ_PUSH: begin
                  if (!stat.free_null) begin
                     cmd.op     = swrb_pkg::OP_RD_LINK;
                     cmd.rd_sel = swrb_pkg::SEL_FREE;
                     state_in   = S_LINK;
                  end else if (!stat.pool_full) begin
                     cmd.op = swrb_pkg::OP_PUSH_NEW;
                  end else begin
                     cmd.st_code = swrb_pkg::ST_POOL_FULL;
                  end
               end
               swrb_pkg::REQ_MOVE, swrb_pkg::REQ_DESTROY: begin
                  if (stat.main_null) begin
                     cmd.st_code = swrb_pkg::ST_MAIN_EMPTY;
                  end else begin
                     cmd.op   = swrb_pkg::OP_RD_LINK;
                     state_in = S_LINK;
                  end
               end
               swrb_pkg::REQ_RESTORE: begin
                  if (stat.bin_null) begin
                     cmd.st_code = swrb_pkg::ST_BIN_EMPTY;
                  end else begin
                     cmd.op     = swrb_pkg::OP_RD_LINK;
                     cmd.rd_sel = swrb_pkg::SEL_BIN;
                     state_in   = S_LINK;
                  end
               end
               swrb_pkg::REQ_CLEAR: begin
                  if (!stat.main_null) begin
                     cmd.op   = swrb_pkg::OP_RD_LINK;
                     state_in = S_LINK;
                  end
               end
               default: begin
                  // peek and the unused kinds
                  if (stat.main_null) cmd.st_code = swrb_pkg::ST_MAIN_EMPTY;
               end
            endcase
         end
         S_LINK: begin
            state_in = S_TOP;
            case (kind_ff)
               swrb_pkg::REQ_PUSH:    cmd.op = swrb_pkg::OP_PUSH_FREE;
               swrb_pkg::REQ_MOVE:    cmd.op = swrb_pkg::OP_MOVE;
               swrb_pkg::REQ_DESTROY: cmd.op = swrb_pkg::OP_DESTROY;
               swrb_pkg::REQ_RESTORE: cmd.op = swrb_pkg::OP_RESTORE;
               swrb_pkg::REQ_CLEAR: begin
                  // one main node back to the free list per pass
                  cmd.op = swrb_pkg::OP_DESTROY;
                  if (!stat.link_null) state_in = S_CLRRD;
               end
               default: cmd.op = swrb_pkg::OP_NONE;
            endcase
         end
         S_CLRRD: begin
            cmd.op   = swrb_pkg::OP_RD_LINK;
            state_in = S_LINK;
         end
         S_TOP: begin
            cmd.op   = swrb_pkg::OP_RD_TOP;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.op       = swrb_pkg::OP_LOAD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
   end

endmodule

@@ rtl/core/swrb_dpath.sv @@
// ----------------------------------------------------------------------------
// swrb_dpath
// Node pool memories, list heads, counts and the result register.
// ----------------------------------------------------------------------------
module swrb_dpath #(
   parameter int POOL_DEPTH = swrb_pkg::POOL_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swrb_pkg::cmd_type                    cmd,
   output swrb_pkg::stat_type                   stat,
   input  logic signed [swrb_pkg::VALUE_W-1:0]  push_value,
   output logic signed [swrb_pkg::VALUE_W-1:0]  top_value,
   output logic                                 top_valid,
   output logic        [swrb_pkg::STAT_W-1:0]   status,
   output logic        [swrb_pkg::CNT_W-1:0]    stack_count,
   output logic        [swrb_pkg::CNT_W-1:0]    bin_count
);

   localparam int IW = $clog2(POOL_DEPTH + 1);
   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam logic [IW-1:0] NULL_IDX = IW'(POOL_DEPTH);

   logic [IW-1:0]                      link_mem [POOL_DEPTH];
   logic [swrb_pkg::VALUE_W-1:0]       val_mem  [POOL_DEPTH];

   logic [IW-1:0] main_head_ff, main_head_in;
   logic [IW-1:0] bin_head_ff,  bin_head_in;
   logic [IW-1:0] free_head_ff, free_head_in;
   logic [IW-1:0] next_new_ff,  next_new_in;
   logic [IW-1:0] main_cnt_ff,  main_cnt_in;
   logic [IW-1:0] bin_cnt_ff,   bin_cnt_in;
   logic [IW-1:0] link_rd_ff;
   logic [IW-1:0] rd_head;
   logic [swrb_pkg::VALUE_W-1:0] val_rd_ff;
   logic [swrb_pkg::VALUE_W-1:0] value_ff;
   logic [swrb_pkg::STAT_W-1:0]  status_ff;

   logic [IW-1:0] node;
   logic [IW-1:0] wr_link;
   logic          link_we;
   logic          val_we;

   logic signed [swrb_pkg::VALUE_W-1:0] top_value_ff;
   logic                                top_valid_ff;
   logic        [swrb_pkg::STAT_W-1:0]  status_out_ff;
   logic        [swrb_pkg::CNT_W-1:0]   stack_count_ff;
   logic        [swrb_pkg::CNT_W-1:0]   bin_count_ff;

   assign stat.main_null     = (main_head_ff >= NULL_IDX);
   assign stat.bin_null      = (bin_head_ff  >= NULL_IDX);
   assign stat.free_null     = (free_head_ff >= NULL_IDX);
   assign stat.pool_full     = (next_new_ff  >= NULL_IDX);
   assign stat.link_null     = (link_rd_ff   >= NULL_IDX);
   assign stat.main_cnt_zero = (main_cnt_ff == '0);

   always_comb begin
      case (cmd.rd_sel)
         swrb_pkg::SEL_BIN:  rd_head = bin_head_ff;
         swrb_pkg::SEL_FREE: rd_head = free_head_ff;
         default:            rd_head = main_head_ff;
      endcase
   end

   always_comb begin
      main_head_in = main_head_ff;
      bin_head_in  = bin_head_ff;
      free_head_in = free_head_ff;
      next_new_in  = next_new_ff;
      main_cnt_in  = main_cnt_ff;
      bin_cnt_in   = bin_cnt_ff;
      node         = main_head_ff;
      wr_link      = main_head_ff;
      link_we      = 1'b0;
      val_we       = 1'b0;
      // a link read from memory that is out of range counts as null
      case (cmd.op)
         swrb_pkg::OP_PUSH_FREE: begin
            node         = free_head_ff;
            free_head_in = stat.link_null ? NULL_IDX : link_rd_ff;
            main_head_in = node;
            link_we      = 1'b1;
            val_we       = 1'b1;
            main_cnt_in  = main_cnt_ff + IW'(1);
         end
         swrb_pkg::OP_PUSH_NEW: begin
            node         = next_new_ff;
            next_new_in  = next_new_ff + IW'(1);
            main_head_in = node;
            link_we      = 1'b1;
            val_we       = 1'b1;
            main_cnt_in  = main_cnt_ff + IW'(1);
         end
         swrb_pkg::OP_MOVE: begin
            main_head_in = stat.link_null ? NULL_IDX : link_rd_ff;
            wr_link      = bin_head_ff;
            bin_head_in  = node;
            link_we      = 1'b1;
            main_cnt_in  = main_cnt_ff - IW'(1);
            bin_cnt_in   = bin_cnt_ff + IW'(1);
         end
         swrb_pkg::OP_DESTROY: begin
            main_head_in = stat.link_null ? NULL_IDX : link_rd_ff;
            wr_link      = free_head_ff;
            free_head_in = node;
            link_we      = 1'b1;
            main_cnt_in  = main_cnt_ff - IW'(1);
         end
         swrb_pkg::OP_RESTORE: begin
            node         = bin_head_ff;
            bin_head_in  = stat.link_null ? NULL_IDX : link_rd_ff;
            main_head_in = node;
            link_we      = 1'b1;
            bin_cnt_in   = bin_cnt_ff - IW'(1);
            main_cnt_in  = main_cnt_ff + IW'(1);
         end
         default: ;
      endcase
   end

   // pool memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (link_we) link_mem[node[AW-1:0]] <= wr_link;
      if (val_we)  val_mem[node[AW-1:0]]  <= value_ff;
      if (cmd.op == swrb_pkg::OP_RD_LINK) link_rd_ff <= link_mem[rd_head[AW-1:0]];
      if (cmd.op == swrb_pkg::OP_RD_TOP && !stat.main_null)
         val_rd_ff <= val_mem[main_head_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_head_ff <= NULL_IDX;
         bin_head_ff  <= NULL_IDX;
         free_head_ff <= NULL_IDX;
         next_new_ff  <= '0;
         main_cnt_ff  <= '0;
         bin_cnt_ff   <= '0;
      end else begin
         main_head_ff <= main_head_in;
         bin_head_ff  <= bin_head_in;
         free_head_ff <= free_head_in;
         next_new_ff  <= next_new_in;
         main_cnt_ff  <= main_cnt_in;
         bin_cnt_ff   <= bin_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_value) value_ff  <= push_value;
      if (cmd.st_ld)     status_ff <= cmd.st_code;
      if (cmd.op == swrb_pkg::OP_LOAD_OUT) begin
         top_value_ff   <= stat.main_null ? '0 : val_rd_ff;
         top_valid_ff   <= !stat.main_null;
         status_out_ff  <= status_ff;
         stack_count_ff <= swrb_pkg::CNT_W'(main_cnt_ff);
         bin_count_ff   <= swrb_pkg::CNT_W'(bin_cnt_ff);
      end
   end

   assign top_value   = top_value_ff;
   assign top_valid   = top_valid_ff;
   assign status      = status_out_ff;
   assign stack_count = stack_count_ff;
   assign bin_count   = bin_count_ff;

endmodule

@@ rtl/core/stack_with_recycle_bin_unit.sv @@
// ----------------------------------------------------------------------------
// stack_with_recycle_bin_unit
// Main stack and recycle bin as two linked lists over one shared node pool.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request item (req_type, push_value); rsp_chan returns
//   exactly one result item per request: the main top, its valid flag, a
//   status code and both counts after the request took effect.
//   One request is in work at a time. After acceptance it steps through
//   decode, which reads the next link for push from the free list, move,
//   destroy, restore and clear of a non-empty stack; then, if a link was
//   read, an update step, alternating with further link reads for clear;
//   then the top read and the load of the result into the output register.
//   req_chan.ready rises at the edge that loads the result, so a new request
//   is not taken before the last one's result is loaded. The steps follow
//   from the registered read of the pool memories: a pop reads the next
//   link, then the new top value. The output register holds a result while
//   rsp_chan stalls; a finished request waits in its last step until that
//   register is free. Reset (synchronous) empties all three lists and the
//   pool; no clearing pass is run, pool entries are only read once linked.
// ----------------------------------------------------------------------------
module stack_with_recycle_bin_unit #(
   parameter int POOL_DEPTH = swrb_pkg::POOL_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   swrb_req_if.sink      req_chan,
   swrb_rsp_if.source    rsp_chan
);

   // command and status between sequencer and datapath
   swrb_pkg::cmd_type   cmd;
   swrb_pkg::stat_type  stat;

   swrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   swrb_dpath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .push_value  (req_chan.push_value),
      .top_value   (rsp_chan.top_value),
      .top_valid   (rsp_chan.top_valid),
      .status      (rsp_chan.status),
      .stack_count (rsp_chan.stack_count),
      .bin_count   (rsp_chan.bin_count)
   );

`ifndef SYNTH
   // only one request in work: no accept right after an accept
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in work");

   // the main head and the main count agree on emptiness
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      stat.main_null == stat.main_cnt_zero)
      else $error("main head and main count disagree");

   // an empty main stack reports a zero top
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.top_valid) |-> (rsp_chan.top_value == '0))
      else $error("nonzero top value on empty stack");
`endif

endmodule

@@ tb/tb_stack_with_recycle_bin_unit.sv @@
// ----------------------------------------------------------------------------
// tb_stack_with_recycle_bin_unit
// Self-checking bench: directed rows over the empty-stack, value-extreme and
// odd-request cases, then mixed fill/churn/drain traffic. An in-bench
// shadow pool predicts results not given by a row; all are compared in order.
// ----------------------------------------------------------------------------
module tb_stack_with_recycle_bin_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import swrb_pkg::*;

   localparam int POOL_DEPTH = POOL_DEPTH_DEF;
   localparam int NODE_AW    = $clog2(POOL_DEPTH);
   localparam logic [CNT_W-1:0] NULL_NODE = CNT_W'(POOL_DEPTH);

   // request kinds with no function of their own; the block answers them as a peek
   localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

   localparam int NUM_DIRECTED  = 24;
   localparam int RANDOM_ITEMS  = 1426;
   localparam int LONG_HOLD     = 400;          // receiver hold-off, in cycles
   localparam int DRAIN_CYCLES  = 2 * POOL_DEPTH + 8; // a full clear plus margin
   localparam int MAX_REPORTS   = 10;
   localparam realtime RUN_LIMIT = 3_000_000ns;

   // one result item as the block reports it
   typedef struct packed {
      logic signed [VALUE_W-1:0] top_value;
      logic                      top_valid;
      logic [STAT_W-1:0]         status;
      logic [CNT_W-1:0]          stack_count;
      logic [CNT_W-1:0]          bin_count;
   } stack_view_type;

   // directed stimulus row; known_view holds only where has_view is set
   typedef struct packed {
      logic [REQ_W-1:0]   kind;
      logic [VALUE_W-1:0] value;
      logic               has_view;
      stack_view_type     known_view;
   } request_row_type;

   typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} traffic_mix_type;

   localparam stack_view_type NO_VIEW = '0;

   logic clock;
   logic reset;

   swrb_req_if req_chan ();
   swrb_rsp_if rsp_chan ();

   stack_with_recycle_bin_unit #(
      .POOL_DEPTH (POOL_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // -------------------------------------------------------------------------
   // Shadow of the node pool: three singly linked lists threaded through one
   // value/link store, plus the never-used watermark.
   // -------------------------------------------------------------------------
   logic [VALUE_W-1:0] node_value [POOL_DEPTH];
   logic [CNT_W-1:0]   node_link  [POOL_DEPTH];
   logic [CNT_W-1:0]   main_top;
   logic [CNT_W-1:0]   bin_top;
   logic [CNT_W-1:0]   free_top;
   logic [CNT_W-1:0]   fresh_next;
   logic [CNT_W-1:0]   main_depth;
   logic [CNT_W-1:0]   bin_depth;

   stack_view_type expected_views [$];

   int unsigned mismatch_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned rsp_hold_cycles;   // set by the sender side, counted down below

   request_row_type directed_rows [NUM_DIRECTED] = '{
      // empty main stack and empty bin
      '{REQ_PEEK,     32'h0000_0000, 1'b1, '{32'sh0, 1'b0, ST_MAIN_EMPTY, 7'd0, 7'd0}},
      '{REQ_MOVE,     32'h0000_0000, 1'b1, '{32'sh0, 1'b0, ST_MAIN_EMPTY, 7'd0, 7'd0}},
      '{REQ_DESTROY,  32'h0000_0000, 1'b1, '{32'sh0, 1'b0, ST_MAIN_EMPTY, 7'd0, 7'd0}},
      '{REQ_RESTORE,  32'h0000_0000, 1'b1, '{32'sh0, 1'b0, ST_BIN_EMPTY,  7'd0, 7'd0}},
      // clear of an empty stack still reports ok
      '{REQ_CLEAR,    32'h0000_0000, 1'b1, '{32'sh0, 1'b0, ST_OK,         7'd0, 7'd0}},
      // value extremes
      '{REQ_PUSH,     32'h7FFF_FFFF, 1'b1,
        '{32'sh7FFF_FFFF, 1'b1, ST_OK, 7'd1, 7'd0}},
      '{REQ_PUSH,     32'h8000_0000, 1'b1,
        '{32'sh8000_0000, 1'b1, ST_OK, 7'd2, 7'd0}},
      '{REQ_PEEK,     32'h0000_0000, 1'b1,
        '{32'sh8000_0000, 1'b1, ST_OK, 7'd2, 7'd0}},
      // move to bin and back
      '{REQ_MOVE,     32'h0000_0000, 1'b1,
        '{32'sh7FFF_FFFF, 1'b1, ST_OK, 7'd1, 7'd1}},
      '{REQ_RESTORE,  32'h0000_0000, 1'b1,
        '{32'sh8000_0000, 1'b1, ST_OK, 7'd2, 7'd0}},
      '{REQ_MOVE,     32'h0000_0000, 1'b1,
        '{32'sh7FFF_FFFF, 1'b1, ST_OK, 7'd1, 7'd1}},
      '{REQ_DESTROY,  32'h0000_0000, 1'b1, '{32'sh0, 1'b0, ST_OK,         7'd0, 7'd1}},
      // unused kind acts as a peek on an empty stack
      '{REQ_UNUSED_6, 32'hFFFF_FFFF, 1'b1, '{32'sh0, 1'b0, ST_MAIN_EMPTY, 7'd0, 7'd1}},
      // reuse of the freed node, then a fresh one
      '{REQ_PUSH,     32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_PUSH,     32'hFFFF_FFFF, 1'b0, NO_VIEW},
      '{REQ_UNUSED_7, 32'h1234_5678, 1'b0, NO_VIEW},
      '{REQ_RESTORE,  32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_CLEAR,    32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_RESTORE,  32'h0000_0000, 1'b1, '{32'sh0, 1'b0, ST_BIN_EMPTY,  7'd0, 7'd0}},
      '{REQ_PUSH,     32'h5555_AAAA, 1'b0, NO_VIEW},
      '{REQ_PUSH,     32'hAAAA_5555, 1'b0, NO_VIEW},
      '{REQ_MOVE,     32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_DESTROY,  32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_CLEAR,    32'h0000_0000, 1'b0, NO_VIEW}
   };

   // clock: 2 ns period
   initial begin
      clock = 1'b0;
      forever #1ns clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // next node under n; anything out of range reads as the end of the list
   function automatic logic [CNT_W-1:0] link_after(input logic [CNT_W-1:0] n);
      return (node_link[n[NODE_AW-1:0]] >= POOL_DEPTH) ? NULL_NODE
                                                       : node_link[n[NODE_AW-1:0]];
   endfunction

   // Apply one request to the shadow pool and return the result it must give.
   function automatic stack_view_type apply_request(input logic [REQ_W-1:0] kind,
                                                    input logic [VALUE_W-1:0] value);
      stack_view_type   view;
      logic [CNT_W-1:0] n;
      int               guard;
      view.status = ST_OK;
      case (kind)
         REQ_PUSH: begin
            if (free_top == NULL_NODE && fresh_next >= POOL_DEPTH) begin
               // pool exhausted: push is dropped
               view.status = ST_POOL_FULL;
            end else begin
               // recycled nodes first, then the never-used ones
               if (free_top != NULL_NODE) begin
                  n        = free_top;
                  free_top = link_after(n);
               end else begin
                  n          = fresh_next;
                  fresh_next = fresh_next + CNT_W'(1);
               end
               node_value[n[NODE_AW-1:0]] = value;
               node_link[n[NODE_AW-1:0]]  = main_top;
               main_top      = n;
               main_depth    = main_depth + CNT_W'(1);
            end
         end
         REQ_MOVE: begin
            if (main_top == NULL_NODE) begin
               view.status = ST_MAIN_EMPTY;
            end else begin
               n            = main_top;
               main_top     = link_after(n);
               node_link[n[NODE_AW-1:0]] = bin_top;
               bin_top      = n;
               main_depth   = main_depth - CNT_W'(1);
               bin_depth    = bin_depth + CNT_W'(1);
            end
         end
         REQ_DESTROY: begin
            if (main_top == NULL_NODE) begin
               view.status = ST_MAIN_EMPTY;
            end else begin
               n            = main_top;
               main_top     = link_after(n);
               node_link[n[NODE_AW-1:0]] = free_top;
               free_top     = n;
               main_depth   = main_depth - CNT_W'(1);
            end
         end
         REQ_RESTORE: begin
            if (bin_top == NULL_NODE) begin
               view.status = ST_BIN_EMPTY;
            end else begin
               n            = bin_top;
               bin_top      = link_after(n);
               node_link[n[NODE_AW-1:0]] = main_top;
               main_top     = n;
               bin_depth    = bin_depth - CNT_W'(1);
               main_depth   = main_depth + CNT_W'(1);
            end
         end
         REQ_CLEAR: begin
            // whole main list onto the free list, bin untouched
            guard = 0;
            while (main_top != NULL_NODE && guard < POOL_DEPTH) begin
               n            = main_top;
               main_top     = link_after(n);
               node_link[n[NODE_AW-1:0]] = free_top;
               free_top     = n;
               guard++;
            end
            main_top   = NULL_NODE;
            main_depth = '0;
         end
         default: begin
            // peek, and the unused kinds
            if (main_top == NULL_NODE) view.status = ST_MAIN_EMPTY;
         end
      endcase
      view.top_valid   = (main_top != NULL_NODE);
      view.top_value   = view.top_valid ? node_value[main_top[NODE_AW-1:0]] : '0;
      view.stack_count = main_depth;
      view.bin_count   = bin_depth;
      return view;
   endfunction

   // Request mix per traffic style; fill drives the pool to exhaustion.
   function automatic logic [REQ_W-1:0] pick_kind(input traffic_mix_type mix);
      int unsigned roll;
      int unsigned w_push, w_move, w_destroy, w_restore, w_peek, w_odd;
      roll = $urandom_range(99);
      case (mix)
         MIX_FILL:  begin
            w_push = 80; w_move = 8;  w_destroy = 4;  w_restore = 4;  w_peek = 2; w_odd = 1;
         end
         MIX_CHURN: begin
            w_push = 40; w_move = 15; w_destroy = 15; w_restore = 15; w_peek = 8; w_odd = 4;
         end
         default:   begin
            w_push = 15; w_move = 15; w_destroy = 40; w_restore = 10; w_peek = 10; w_odd = 5;
         end
      endcase
      if (roll < w_push) return REQ_PUSH;
      roll -= w_push;
      if (roll < w_move) return REQ_MOVE;
      roll -= w_move;
      if (roll < w_destroy) return REQ_DESTROY;
      roll -= w_destroy;
      if (roll < w_restore) return REQ_RESTORE;
      roll -= w_restore;
      if (roll < w_peek) return REQ_PEEK;
      roll -= w_peek;
      if (roll < w_odd) return ($urandom_range(1) == 0) ? REQ_UNUSED_6 : REQ_UNUSED_7;
      return REQ_CLEAR;   // whatever weight is left
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Offer one item (after a random gap), wait for the handshake and record
   // its expected result. valid stays high on return; the caller's next
   // assignment in the same step is the only one made to it.
   task automatic send_request(input logic [REQ_W-1:0] kind,
                               input logic [VALUE_W-1:0] value,
                               input logic has_view,
                               input stack_view_type known_view);
      stack_view_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.push_value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // accepted at this edge
      predicted = apply_request(kind, value);
      expected_views.push_back(has_view ? known_view : predicted);
   endtask

   // Drop valid and wait until every outstanding result has come back.
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_views.size() != 0) @(posedge clock);
   endtask

   // Random traffic in bursts of one mix each.
   task automatic send_random(input int unsigned count);
      int unsigned     sent;
      int unsigned     burst;
      traffic_mix_type mix;
      sent = 0;
      while (sent < count) begin
         mix   = traffic_mix_type'($urandom_range(2));
         burst = $urandom_range(20, 70);
         while (burst != 0 && sent < count) begin
            send_request(pick_kind(mix), pick_value(), 1'b0, NO_VIEW);
            burst--;
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: check every accepted item against the oldest expectation,
   // then choose ready for the next cycle (random, or held off on request).
   // -------------------------------------------------------------------------
   initial begin
      stack_view_type want;
      stack_view_type got;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.top_value   = rsp_chan.top_value;
            got.top_valid   = rsp_chan.top_valid;
            got.status      = rsp_chan.status;
            got.stack_count = rsp_chan.stack_count;
            got.bin_count   = rsp_chan.bin_count;
            if (expected_views.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"[%0t] result with none pending: ",
                            "top=%h valid=%b st=%0d cnt=%0d bin=%0d"},
                           $realtime, got.top_value, got.top_valid, got.status,
                           got.stack_count, got.bin_count);
            end else begin
               want = expected_views.pop_front();
               if (got.top_value !== want.top_value || got.top_valid !== want.top_valid ||
                   got.status !== want.status || got.stack_count !== want.stack_count ||
                   got.bin_count !== want.bin_count) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"[%0t] result differs: ",
                               "exp top=%h valid=%b st=%0d cnt=%0d bin=%0d, ",
                               "got top=%h valid=%b st=%0d cnt=%0d bin=%0d"},
                              $realtime, want.top_value, want.top_valid, want.status,
                              want.stack_count, want.bin_count, got.top_value,
                              got.top_valid, got.status, got.stack_count,
                              got.bin_count);
               end
            end
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_hold_cycles != 0) begin
            // long back-pressure: block's output register fills, input stalls
            rsp_chan.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side: reset, directed rows, then three random phases with
   // different gap patterns.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned row;
      mismatch_count  = 0;
      rsp_hold_cycles = 0;
      send_idle_pct   = 17;
      recv_idle_pct   = 66;

      // shadow pool after reset: all lists empty, nothing used yet
      main_top   = NULL_NODE;
      bin_top    = NULL_NODE;
      free_top   = NULL_NODE;
      fresh_next = '0;
      main_depth = '0;
      bin_depth  = '0;
      node_value = '{default: '0};
      node_link  = '{default: NULL_NODE};

      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= REQ_PEEK;
      req_chan.push_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 1: sender sparse gaps, receiver mostly stalled
      row = 0;
      while (row < NUM_DIRECTED) begin
         send_request(directed_rows[row].kind, directed_rows[row].value,
                      directed_rows[row].has_view, directed_rows[row].known_view);
         row++;
      end
      send_random(476);

      // phase 2: sender mostly idle, receiver fast; a full pause in the middle
      send_idle_pct = 66;
      recv_idle_pct = 17;
      send_random(240);
      hold_until_drained();
      send_random(235);

      // phase 3: no idling, but one long receiver hold-off at its start
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      rsp_hold_cycles = LONG_HOLD;
      send_random(RANDOM_ITEMS - 476 - 240 - 235);

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_views.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
